[src/sbcl_pkg.sv]
// Shared types and constants of the swept box collision limiter.
package sbcl_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COLLIDE = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  localparam int unsigned DivW      = 52;
  localparam int unsigned DivDigits = 4;
  localparam int unsigned DivIters  = DivW / DivDigits;
  localparam int unsigned DivCntW   = $clog2(DivIters);

  localparam logic signed [63:0] TimeInf = 64'sd1 <<< 62;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[src/swept_box_collision_limiter.sv]
// Top level of the swept box collision limiter: sequencer, body state, step multiplier.
//
// Channels: s_axis carries one command item (tuser = cmd) with velocities, both
// boxes and the step time in tdata. m_axis returns exactly one result item per
// command. cfg_* writes stop_threshold (Q16.16) at any edge with valid and ready.
// Load and unused commands go from idle straight to the finish state. A step
// uses the one 33x32 multiplier once per axis, its product registered.
// A collide runs four entry times (near/far per axis) one after another
// through the shared radix-16 divider (start, 13 steps, capture each),
// followed by the decision state ST_DEC. One item is in
// flight at a time; tready is high only while the sequencer is idle.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result waits in the sequencer until m_axis_tready_i.
// Reset clears velocities and the grounded flag, sets both time limits to
// unlimited and the threshold to 655; no clearing pass is needed.
module swept_box_collision_limiter #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // vel_x, vel_y, body l/t/r/b, obstacle l/t/r/b, step_time; 32 bits each
  input  logic [351:0] s_axis_tdata_i,
  // cmd
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // move_x, move_y, current_vel_x, current_vel_y, on_ground, hit, 6 zero bits
  output logic [135:0] m_axis_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);
  import sbcl_pkg::*;

  localparam int unsigned CW = (COORD_BITS < 32) ? COORD_BITS : 32;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WDIV = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  function automatic logic signed [32:0] sx(input logic [31:0] v);
    logic [31:0]        s;
    logic signed [31:0] t;
    s = v << (32 - CW);
    t = $signed(s) >>> (32 - CW);
    return {t[31], t};
  endfunction

  function automatic logic [31:0] lower(input logic [31:0] lim,
                                        input logic signed [63:0] nr);
    if (nr <= 0) return '0;
    if (nr < $signed({32'b0, lim})) return nr[31:0];
    return lim;
  endfunction

  logic [2:0]         state_q;
  logic [1:0]         k_q;
  logic [1:0]         cmd_q;
  logic [31:0]        thr_q, vel_x_q, vel_y_q, lim_x_q, lim_y_q, dt_q;
  logic               gnd_q, hit_q;
  logic signed [32:0] bl_q, bt_q, br_q, bb_q, ol_q, ot_q, or_q, ob_q;
  logic signed [63:0] t_q [4];
  logic signed [64:0] prod_q;
  logic [31:0]        mx_q, my_q;
  logic               out_valid_q;
  logic [135:0]       out_data_q;

  div_stat_t          dstat;
  logic signed [63:0] quot;
  logic               div_start;
  logic signed [33:0] dspan;
  logic signed [31:0] dsor;
  logic signed [DivW-1:0] dvd;

  logic               vx0, vy0, ovx, ovy, miss;
  logic signed [63:0] nx, fx, ny, fy, fmin;
  logic [31:0]        nlx, nly;
  logic signed [64:0] adj, shr;
  logic [31:0]        mv, mvel, mt, mlim;
  logic               fin_go;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign div_start       = (state_q == ST_DIV);
  assign fin_go          = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    unique case (k_q)
      2'd0: dspan = !vel_x_q[31] ? 34'(ol_q) - 34'(br_q) : 34'(or_q) - 34'(bl_q);
      2'd1: dspan = !vel_x_q[31] ? 34'(or_q) - 34'(bl_q) : 34'(ol_q) - 34'(br_q);
      2'd2: dspan = !vel_y_q[31] ? 34'(ot_q) - 34'(bb_q) : 34'(ob_q) - 34'(bt_q);
      default: dspan = !vel_y_q[31] ? 34'(ob_q) - 34'(bt_q) : 34'(ot_q) - 34'(bb_q);
    endcase
    dsor = k_q[1] ? vel_y_q : vel_x_q;
    dvd  = {{(DivW - 50){dspan[33]}}, dspan, 16'b0};
  end

  sbcl_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dsor),
    .stat_o     (dstat),
    .quot_o     (quot)
  );

  always_comb begin
    vx0  = (vel_x_q == '0);
    vy0  = (vel_y_q == '0);
    ovx  = (ol_q < br_q) && (bl_q < or_q);
    ovy  = (ot_q < bb_q) && (bt_q < ob_q);
    nx   = vx0 ? -TimeInf : t_q[0];
    fx   = vx0 ? TimeInf : t_q[1];
    ny   = vy0 ? -TimeInf : t_q[2];
    fy   = vy0 ? TimeInf : t_q[3];
    fmin = (fx < fy) ? fx : fy;
    miss = (vx0 && !ovx) || (vy0 && !ovy) || (nx > fy) || (ny > fx) || (fmin <= 0);
    nlx  = lower(lim_x_q, nx);
    nly  = lower(lim_y_q, ny);
  end

  always_comb begin
    mvel = k_q[0] ? vel_y_q : vel_x_q;
    mlim = k_q[0] ? lim_y_q : lim_x_q;
    mt   = (dt_q < mlim) ? dt_q : mlim;
    adj  = prod_q[64] ? prod_q + 65'sd65535 : prod_q;
    shr  = adj >>> 16;
    if (shr > 65'sd2147483647) mv = 32'h7FFF_FFFF;
    else if (shr < -65'sd2147483648) mv = 32'h8000_0000;
    else mv = shr[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      thr_q       <= 32'd655;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      lim_x_q     <= '1;
      lim_y_q     <= '1;
      gnd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      if (fin_go) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          k_q <= '0;
          if (s_axis_tvalid_i) begin
            unique case (cmd_e'(s_axis_tuser_i))
              CMD_LOAD: begin
                vel_x_q <= s_axis_tdata_i[31:0];
                vel_y_q <= s_axis_tdata_i[63:32];
                state_q <= ST_FIN;
              end
              CMD_COLLIDE: state_q <= ST_DIV;
              CMD_STEP:    state_q <= ST_MUL;
              default:     state_q <= ST_FIN;
            endcase
          end
        end
        ST_DIV: state_q <= ST_WDIV;
        ST_WDIV: begin
          if (dstat.done) begin
            k_q     <= k_q + 1'b1;
            state_q <= (k_q == 2'd3) ? ST_DEC : ST_DIV;
          end
        end
        ST_DEC: begin
          state_q <= ST_FIN;
          if (!miss) begin
            if (nx > ny) begin
              lim_x_q <= nlx;
              if (nlx < thr_q) vel_x_q <= '0;
            end else begin
              lim_y_q <= nly;
              if (nly < thr_q) begin
                vel_y_q <= '0;
                if (!vel_y_q[31]) gnd_q <= 1'b1;
              end
            end
          end
        end
        ST_MUL: begin
          k_q <= k_q + 1'b1;
          if (k_q == 2'd2) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            state_q <= ST_IDLE;
            if (cmd_q == CMD_STEP) begin
              lim_x_q <= '1;
              lim_y_q <= '1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q <= s_axis_tuser_i;
      bl_q  <= sx(s_axis_tdata_i[95:64]);
      bt_q  <= sx(s_axis_tdata_i[127:96]);
      br_q  <= sx(s_axis_tdata_i[159:128]);
      bb_q  <= sx(s_axis_tdata_i[191:160]);
      ol_q  <= sx(s_axis_tdata_i[223:192]);
      ot_q  <= sx(s_axis_tdata_i[255:224]);
      or_q  <= sx(s_axis_tdata_i[287:256]);
      ob_q  <= sx(s_axis_tdata_i[319:288]);
      dt_q  <= s_axis_tdata_i[351:320];
      mx_q  <= '0;
      my_q  <= '0;
      hit_q <= 1'b0;
    end
    if (state_q == ST_WDIV && dstat.done) t_q[k_q] <= quot;
    if (state_q == ST_DEC) hit_q <= !miss;
    if (state_q == ST_MUL) begin
      prod_q <= $signed(mvel) * $signed({1'b0, mt});
      if (k_q == 2'd1) mx_q <= mv;
      if (k_q == 2'd2) my_q <= mv;
    end
    if (fin_go) out_data_q <= {6'b0, hit_q, gnd_q, vel_y_q, vel_x_q, my_q, mx_q};
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_gnd_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(gnd_q))
    else $error("grounded flag cleared");
  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstat.busy |-> state_q == ST_WDIV)
    else $error("divider running outside wait state");
  a_step_unlim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && cmd_q == CMD_STEP) |=> (lim_x_q == '1 && lim_y_q == '1))
    else $error("limits not restored after step");
  a_hit_nomove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[129]) |-> (out_data_q[63:0] == '0))
    else $error("hit item with nonzero move");
`endif

endmodule

[src/sbcl_div.sv]
// Iterative signed divider, four quotient bits per cycle, truncating toward zero.
module sbcl_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [sbcl_pkg::DivW-1:0] dividend_i,
  input  logic signed [31:0]              divisor_i,
  output sbcl_pkg::div_stat_t             stat_o,
  output logic signed [63:0]              quot_o
);
  import sbcl_pkg::*;

  logic                 busy_q, busy_d, done_q, done_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic [31:0]          den_q, den_d;
  logic [32:0]          rem_q, rem_d, rem_w;
  logic [DivW-1:0]      quo_q, quo_d, quo_w, quo_s;

  always_comb begin
    rem_w = rem_q;
    quo_w = quo_q;
    for (int i = 0; i < DivDigits; i++) begin
      rem_w = {rem_w[31:0], quo_w[DivW-1]};
      quo_w = {quo_w[DivW-2:0], 1'b0};
      if (rem_w >= {1'b0, den_q}) begin
        rem_w    = rem_w - {1'b0, den_q};
        quo_w[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[DivW-1] ^ divisor_i[31];
      den_d  = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i[DivW-1] ? DivW'(-dividend_i) : dividend_i;
    end else if (busy_q) begin
      rem_d = rem_w;
      quo_d = quo_w;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivIters - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_s       = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o      = {{(64 - DivW){quo_s[DivW-1]}}, quo_s};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
